// ----- hdl/msrq_pkg.sv -----
// ----------------------------------------------------------------------------
// msrq_pkg
// Shared types and constants for the sorted ready queue: transaction
// payloads, queue entry layout, codes and controller/datapath handshake.
// ----------------------------------------------------------------------------
package msrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_POP    = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] MODE_ARRIVAL  = 2'd0;
   localparam logic [1:0] MODE_BURST    = 2'd1;
   localparam logic [1:0] MODE_PRIORITY = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [15:0]        proc_id;
      logic [15:0]        sort_key;
      logic [1:0]         op_code;
      logic signed [31:0] first_operand;
      logic signed [31:0] second_operand;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        out_proc_id;
      logic [15:0]        out_sort_key;
      logic [1:0]         out_op_code;
      logic signed [31:0] out_first;
      logic signed [31:0] out_second;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        proc_id;
      logic [15:0]        sort_key;
      logic [1:0]         op_code;
      logic signed [31:0] first;
      logic signed [31:0] second;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;     // latch request, rewind scan index
      logic       step;     // advance scan index
      logic       place;    // open gap at scan index and write new entry
      logic       pop;      // return head and shift toward head
      logic       respond;  // drive result strobe next cycle
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic scan_hit;
   } stat_type;

endpackage

// ----- hdl/mode_sorted_ready_queue_core.sv -----
// Sequence: pop and refused insert respond from the check state; an insert
// steps the scan state from the head slot until it lands at slot k, then responds.
// Throughput: one transaction at a time; the linear position scan, one slot
// compare per cycle, sets the insert time. A new start is taken in the strobe cycle.
// Reset (synchronous): queue empty, order mode arrival; results cannot be stalled.
// ----------------------------------------------------------------------------
// mode_sorted_ready_queue_core
// Sorted scheduler ready queue: insert a job record in mode order, pop head.
// ----------------------------------------------------------------------------
module mode_sorted_ready_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  msrq_pkg::req_type req_item,
   output logic              rsp_valid,
   output msrq_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_wdata
);

   msrq_pkg::cmd_type  cmd;
   msrq_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   msrq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   msrq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- hdl/msrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// msrq_ctrl
// Controller for the sorted ready queue: accepts a transaction, sorts out
// pop, refusal or insert, and steps the position scan until it lands.
// ----------------------------------------------------------------------------
module msrq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msrq_pkg::stat_type stat,
   output msrq_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (stat.is_pop && stat.empty) begin
               cmd.respond = 1'b1;
               cmd.status  = msrq_pkg::STATUS_EMPTY;
               state_in    = ST_IDLE;
            end else if (stat.is_pop) begin
               cmd.pop     = 1'b1;
               cmd.respond = 1'b1;
               cmd.status  = msrq_pkg::STATUS_DONE;
               state_in    = ST_IDLE;
            end else if (stat.full) begin
               cmd.respond = 1'b1;
               cmd.status  = msrq_pkg::STATUS_FULL;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_hit) begin
               cmd.place   = 1'b1;
               cmd.respond = 1'b1;
               cmd.status  = msrq_pkg::STATUS_DONE;
               state_in    = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hdl/msrq_datapath.sv -----
// ----------------------------------------------------------------------------
// msrq_datapath
// Slot row, occupancy count, scan index and order compare for the sorted
// ready queue, plus the mode register and the result register.
// ----------------------------------------------------------------------------
module msrq_datapath (
   input  logic               clock,
   input  logic               reset,
   input  msrq_pkg::req_type  req_item,
   input  logic               csr_valid,
   input  logic [1:0]         csr_wdata,
   input  msrq_pkg::cmd_type  cmd,
   output msrq_pkg::stat_type stat,
   output logic               rsp_valid,
   output msrq_pkg::rsp_type  rsp_item
);

   localparam int DEPTH = msrq_pkg::QUEUE_DEPTH;
   localparam int IDX_W = msrq_pkg::IDX_W;
   localparam int CNT_W = msrq_pkg::CNT_W;

   logic [1:0]             mode_ff;
   msrq_pkg::req_type      req_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [CNT_W-1:0]       occ_ff;
   logic                   rsp_valid_ff;
   msrq_pkg::rsp_type      rsp_ff, rsp_in;
   msrq_pkg::entry_type    slot_ff [DEPTH];
   msrq_pkg::entry_type    slot_in [DEPTH];
   msrq_pkg::entry_type    new_entry;
   msrq_pkg::entry_type    probe;
   logic                   goes_before;

   assign new_entry = '{proc_id:  req_ff.proc_id,
                        sort_key: req_ff.sort_key,
                        op_code:  req_ff.op_code,
                        first:    req_ff.first_operand,
                        second:   req_ff.second_operand};

   assign probe = slot_ff[idx_ff];

   // new entry goes ahead of the first stored entry that does not sort before it
   always_comb begin
      unique case (mode_ff)
         msrq_pkg::MODE_BURST:
            goes_before = (probe.sort_key >= req_ff.sort_key);
         msrq_pkg::MODE_PRIORITY:
            goes_before = (probe.sort_key > req_ff.sort_key) ||
                          ((probe.sort_key == req_ff.sort_key) &&
                           (probe.proc_id >= req_ff.proc_id));
         default:
            goes_before = (probe.proc_id >= req_ff.proc_id);
      endcase
   end

   assign stat.is_pop   = (req_ff.operation == msrq_pkg::OP_POP);
   assign stat.empty    = (occ_ff == '0);
   assign stat.full     = (occ_ff == CNT_W'(DEPTH));
   assign stat.scan_hit = (CNT_W'(idx_ff) == occ_ff) || goes_before;

   for (genvar g = 0; g < DEPTH; g++) begin : g_slot
      always_comb begin
         slot_in[g] = slot_ff[g];
         if (cmd.place) begin
            if (IDX_W'(g) == idx_ff) begin
               slot_in[g] = new_entry;
            end
            if (g > 0) begin
               if (IDX_W'(g) > idx_ff) begin
                  slot_in[g] = slot_ff[(g > 0) ? g - 1 : 0];
               end
            end
         end else if (cmd.pop) begin
            if (g < DEPTH - 1) begin
               slot_in[g] = slot_ff[(g < DEPTH - 1) ? g + 1 : g];
            end
         end
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = cmd.status;
      if (cmd.pop) begin
         rsp_in.out_proc_id  = slot_ff[0].proc_id;
         rsp_in.out_sort_key = slot_ff[0].sort_key;
         rsp_in.out_op_code  = slot_ff[0].op_code;
         rsp_in.out_first    = slot_ff[0].first;
         rsp_in.out_second   = slot_ff[0].second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= msrq_pkg::MODE_ARRIVAL;
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_wdata;
         end
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.place) begin
            occ_ff <= occ_ff + 1'b1;
         end else if (cmd.pop) begin
            occ_ff <= occ_ff - 1'b1;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
